// ----- hdl/pcrc_pkg.sv -----
// shared constants for the programmable crc generator and checker
package pcrc_pkg;

    // default and fixed widths
    localparam int MAX_CRC_WIDTH_DEF = 32;
    localparam int CW_BITS           = 6;
    localparam int POLY_BITS         = 32;
    localparam int STEPS             = 8;

    // register values after reset: generator x^3 + 1
    localparam logic [CW_BITS-1:0]   CRC_WIDTH_RST = 6'd3;
    localparam logic [POLY_BITS-1:0] POLY_RST      = 32'd1;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CRC_WIDTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLY_LOW  = 1'd1;

endpackage

// ----- hdl/programmable_crc_generate_check.sv -----
// programmable msb-first crc generator and checker, top level
//
// Input words on s_*: one message byte per word, s_tlast on the final byte,
// and the received crc in the upper tdata bits (zero to generate a crc).
// On the final byte one result word leaves on m_*: the remainder xor the
// received crc in m_tdata, and m_tuser high when that value is nonzero.
// Other bytes give no result word. After a final byte the remainder clears.
// cfg_* writes crc_width (index 0) and poly_low_bits (index 1); cfg_ready is
// always high; the user must write only while no message byte is in flight,
// unenforced by the block. Throughput: one byte per clock while s_tready is high.
// All eight bit steps of a byte go through the row of bit cells in the same cycle,
// the quotient bits coming from a small eight-bit window unit, so the remainder
// is ready for the next byte. Latency: the result word is valid in the cycle after
// its final byte. A stalled m_tready holds the result word; s_tready stays high
// while the output register is empty or being drained, so bytes keep flowing.
// Reset clears the remainder, the output valid, and sets width 3, poly 1.
module programmable_crc_generate_check
    import pcrc_pkg::*;
#(
    parameter int MAX_CRC_WIDTH = MAX_CRC_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [39:0]             s_tdata,   // data_byte[7:0], received_crc[39:8]
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,   // crc_value[31:0]
    output logic                    m_tuser,   // error_detected[0]
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [31:0]             cfg_data
);

    localparam int M  = MAX_CRC_WIDTH;
    localparam int WW = $clog2(MAX_CRC_WIDTH + 1);

    logic [CW_BITS-1:0]   crc_width_reg;
    logic [POLY_BITS-1:0] poly_reg;
    logic [WW-1:0]        eff_w;
    logic [WW-1:0]        align_sh;
    logic [M-1:0]         wmask;
    logic [M-1:0]         poly_ext;
    logic [M-1:0]         rx_ext;
    logic [M-1:0]         rem_q;
    logic [M-1:0]         rem_left;
    logic [M-1:0]         gen_left;
    logic [M-1:0]         res_left;
    logic [M-1:0]         rem_right;
    logic [M-1:0]         rem_next;
    logic [M-1:0]         result;
    logic [31:0]          result32;
    logic [STEPS-1:0]     rem_top;
    logic [STEPS-1:0]     gen_top;
    logic [STEPS-1:0]     top;
    logic [M-1:0][STEPS-1:0] step_bits;
    logic                 in_accept;
    logic                 m_tvalid_reg;
    logic [31:0]          crc_reg;
    logic                 err_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_width_reg <= CRC_WIDTH_RST;
            poly_reg      <= POLY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CRC_WIDTH: crc_width_reg <= cfg_data[CW_BITS-1:0];
                CFG_POLY_LOW:  poly_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective width, clamped to one and to the column count
    always_comb
    begin
        if (crc_width_reg == '0)
            eff_w = WW'(1);
        else if (int'(crc_width_reg) > M)
            eff_w = WW'(M);
        else
            eff_w = WW'(crc_width_reg);
    end

    assign align_sh = WW'(M) - eff_w;
    assign wmask    = {M{1'b1}} >> align_sh;

    // fit the 32-bit fields to the column count
    if (M <= 32)
    begin : g_narrow
        assign poly_ext = poly_reg[M-1:0];
        assign rx_ext   = s_tdata[8 +: M];
        assign result32 = {{(32-M){1'b0}}, result};
    end
    else
    begin : g_wide
        assign poly_ext = {{(M-32){1'b0}}, poly_reg};
        assign rx_ext   = {{(M-32){1'b0}}, s_tdata[39:8]};
        assign result32 = result[31:0];
    end

    // msb-justify remainder and generator; the shift drops bits above width
    assign rem_left = rem_q << align_sh;
    assign gen_left = poly_ext << align_sh;

    // top eight columns for the quotient unit, zero below column zero
    for (genvar t = 0; t < STEPS; t++)
    begin : g_win
        if (M - 1 - t >= 0)
        begin : g_in
            assign rem_top[STEPS-1-t] = rem_left[M-1-t];
            assign gen_top[STEPS-1-t] = gen_left[M-1-t];
        end
        else
        begin : g_pad
            assign rem_top[STEPS-1-t] = 1'b0;
            assign gen_top[STEPS-1-t] = 1'b0;
        end
    end

    pcrc_quot u_quot
    (
        .data_byte (s_tdata[7:0]),
        .rem_top   (rem_top),
        .gen_top   (gen_top),
        .top       (top)
    );

    assign in_accept = s_tvalid && s_tready;

    // row of bit cells, each shifting into its upper neighbor
    for (genvar j = 0; j < M; j++)
    begin : g_cell
        logic [STEPS-1:0] nb_src;

        if (j == 0)
        begin : g_first
            assign nb_src = '0;
        end
        else
        begin : g_next
            assign nb_src = step_bits[j-1];
        end

        pcrc_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (in_accept),
            .bit_next    (rem_next[j]),
            .aligned_bit (rem_left[j]),
            .gen_bit     (gen_left[j]),
            .top         (top),
            .nb_in       (nb_src),
            .bit_q       (rem_q[j]),
            .nb_out      (step_bits[j]),
            .res_bit     (res_left[j])
        );
    end

    // back to lsb-justified form, cleared after the final byte
    assign rem_right = res_left >> align_sh;
    assign rem_next  = s_tlast ? '0 : rem_right;
    assign result    = rem_right ^ (rx_ext & wmask);

    // output register
    assign s_tready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (in_accept && s_tlast)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && s_tlast)
        begin
            crc_reg <= result32;
            err_reg <= |result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = crc_reg;
    assign m_tuser  = err_reg;

endmodule

// ----- hdl/pcrc_cell.sv -----
// one bit column of the remainder: stored bit plus eight division steps
module pcrc_cell
    import pcrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             bit_next,
    input  logic             aligned_bit,
    input  logic             gen_bit,
    input  logic [STEPS-1:0] top,
    input  logic [STEPS-1:0] nb_in,
    output logic             bit_q,
    output logic [STEPS-1:0] nb_out,
    output logic             res_bit
);

    logic bit_reg;
    logic [STEPS:0] step_val;

    // value of this column after each step, neighbor feeds the shift
    always_comb
    begin
        step_val[0] = aligned_bit;
        for (int k = 0; k < STEPS; k++)
        begin
            step_val[k+1] = nb_in[k] ^ (top[k] & gen_bit);
        end
    end

    assign nb_out  = step_val[STEPS-1:0];
    assign res_bit = step_val[STEPS];

    // stored remainder bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_reg <= 1'b0;
        else if (en)
            bit_reg <= bit_next;
    end

    assign bit_q = bit_reg;

endmodule

// ----- hdl/pcrc_quot.sv -----
// quotient bits of one byte, worked out on the top eight columns
module pcrc_quot
    import pcrc_pkg::*;
(
    input  logic [STEPS-1:0] data_byte,
    input  logic [STEPS-1:0] rem_top,
    input  logic [STEPS-1:0] gen_top,
    output logic [STEPS-1:0] top
);

    // short division on the window that reaches the msb within a byte
    always_comb
    begin
        logic [STEPS-1:0] win;
        logic             fb;
        win = rem_top;
        top = '0;
        for (int k = 0; k < STEPS; k++)
        begin
            fb     = win[STEPS-1] ^ data_byte[STEPS-1-k];
            top[k] = fb;
            win    = {win[STEPS-2:0], 1'b0} ^ (fb ? gen_top : '0);
        end
    end

endmodule

// ----- hdl/pcrc_checker.sv -----
// port-level checks for the crc block, bound to the top level
module pcrc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // a nonzero check value always raises the error flag
    a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata != 32'd0) |-> m_tuser)
        else $error("error flag low on nonzero crc word");

    // a final byte always yields a result word next cycle
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("final byte gave no result word");

    // a new result word only follows an accepted final byte
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result word without a final byte");

    // input side never blocks while the output register is empty
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

endmodule

bind programmable_crc_generate_check pcrc_checker u_pcrc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
